// ===== rtl/socc_pkg.sv =====
`default_nettype none
package socc_pkg;

  localparam int MaxObstacles = 32;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] CFG_X_MAX = 2'd0;
  localparam logic [1:0] CFG_X_MIN = 2'd1;
  localparam logic [1:0] CFG_PEN   = 2'd2;

  localparam logic [13:0]        XMaxReset = 14'd6000;
  localparam logic signed [14:0] XMinReset = -15'sd6000;
  localparam logic [11:0]        PenReset  = 12'd1200;

  localparam int InDataW  = 120;
  localparam int OutDataW = 8;

  typedef struct packed {
    logic signed [14:0] sx;
    logic signed [14:0] sy;
    logic signed [14:0] gx;
    logic signed [14:0] gy;
    logic [11:0]        margin;
  } query_t;

  typedef struct packed {
    logic signed [14:0] cx;
    logic signed [14:0] cy;
    logic [11:0]        rad;
  } obs_t;

  typedef struct packed {
    logic [1:0] action;
    logic       same;
    query_t     q;
    obs_t       o;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/segment_obstacle_clearance_check.sv =====
// Segment obstacle clearance check. Clear (tuser 0) and append (tuser 1)
// transfers load a table of up to MAX_OBSTACLES circles; a query (tuser 2)
// reports whether the segment start->goal is blocked by any stored circle or
// by the two fixed penalty circles. Every input transfer yields exactly one
// output transfer. A two-entry queue separates the input side from the
// query engine, so up to two items can be taken while the engine is busy.
// A query whose start equals its goal is not checked and reports unblocked.
// Other queries walk the table and then both penalty circles one circle at
// a time through a single shared 33x33 multiplier; a circle that passes the
// line distance test also runs two 13-step offset searches, and the walk
// stops at the first hit.
`default_nettype none
module segment_obstacle_clearance_check #(
  parameter int MAX_OBSTACLES = socc_pkg::MaxObstacles
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // action
  input  wire logic [1:0]                    in_tuser,
  // start_x, start_y, goal_x, goal_y, margin, obstacle_cx, obstacle_cy,
  // obstacle_radius, zero pad
  input  wire logic [socc_pkg::InDataW-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // blocked, status, zero pad
  output logic [socc_pkg::OutDataW-1:0]      out_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [14:0]                   cfg_wdata
);

  logic           cmd_valid, cmd_ready;
  socc_pkg::cmd_t cmd;

  socc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  socc_back #(
    .MAX_OBSTACLES (MAX_OBSTACLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== rtl/socc_front.sv =====
`default_nettype none
module socc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [1:0]                    in_tuser,
  input  wire logic [socc_pkg::InDataW-1:0]  in_tdata,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output socc_pkg::cmd_t                     cmd
);

  socc_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  socc_pkg::cmd_t in_cmd;
  logic           push, pop;

  always_comb begin
    in_cmd.action   = in_tuser;
    in_cmd.q.sx     = $signed(in_tdata[14:0]);
    in_cmd.q.sy     = $signed(in_tdata[29:15]);
    in_cmd.q.gx     = $signed(in_tdata[44:30]);
    in_cmd.q.gy     = $signed(in_tdata[59:45]);
    in_cmd.q.margin = in_tdata[71:60];
    in_cmd.o.cx     = $signed(in_tdata[86:72]);
    in_cmd.o.cy     = $signed(in_tdata[101:87]);
    in_cmd.o.rad    = in_tdata[113:102];
    in_cmd.same     = (in_tdata[29:0] == in_tdata[59:30]);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/socc_hit.sv =====
`default_nettype none
module socc_hit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire socc_pkg::query_t q,
  input  wire socc_pkg::obs_t   o,
  output logic                  done,
  output logic                  hit
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PREP = 5'd1;
  localparam logic [4:0] S_M1   = 5'd2;
  localparam logic [4:0] S_M2   = 5'd3;
  localparam logic [4:0] S_M3   = 5'd4;
  localparam logic [4:0] S_M4   = 5'd5;
  localparam logic [4:0] S_M5   = 5'd6;
  localparam logic [4:0] S_M6   = 5'd7;
  localparam logic [4:0] S_M7   = 5'd8;
  localparam logic [4:0] S_CMP  = 5'd9;
  localparam logic [4:0] S_O1   = 5'd10;
  localparam logic [4:0] S_O2   = 5'd11;
  localparam logic [4:0] S_NUM  = 5'd12;
  localparam logic [4:0] S_T1   = 5'd13;
  localparam logic [4:0] S_T2   = 5'd14;
  localparam logic [4:0] S_TCHK = 5'd15;
  localparam logic [4:0] S_BOX  = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0]          st_r;
  socc_pkg::query_t    q_r;
  socc_pkg::obs_t      o_r;
  logic signed [15:0]  dx_r, dy_r, relx_r, rely_r;
  logic [12:0]         k_r;
  logic [31:0]         s_r;
  logic signed [33:0]  cr_r;
  logic [25:0]         kk_r;
  logic                big_r;
  logic [62:0]         acq_r;
  logic [56:0]         num_r;
  logic [12:0]         lo_r;
  logic [3:0]          bidx_r;
  logic                ph_r;
  logic signed [13:0]  ox_r, oy_r;
  logic                hit_r;
  logic signed [63:0]  mul_r;

  logic signed [32:0]  op_a, op_b;
  logic signed [65:0]  prod;
  logic [33:0]         ac;
  logic signed [15:0]  d;
  logic [12:0]         cand, lo_nxt;
  logic                take;
  logic signed [13:0]  off_nxt;
  logic signed [17:0]  px1, px2, py1, py2, minx, maxx, miny, maxy;
  logic signed [17:0]  cxp, cxm, cyp, cym;
  logic                box_hit;

  always_comb begin
    ac   = cr_r[33] ? 34'(-cr_r) : 34'(cr_r);
    d    = ph_r ? dy_r : dx_r;
    cand = lo_r | (13'd1 << bidx_r);
    take = (mul_r[62:0] <= 63'(num_r));
    lo_nxt = take ? cand : lo_r;
    off_nxt = d[15] ? -$signed({1'b0, lo_nxt}) : $signed({1'b0, lo_nxt});
    op_a = '0;
    op_b = '0;
    case (st_r)
      S_M1:    begin op_a = 33'(dx_r);          op_b = 33'(dx_r); end
      S_M2:    begin op_a = 33'(dy_r);          op_b = 33'(dy_r); end
      S_M3:    begin op_a = 33'(dy_r);          op_b = 33'(relx_r); end
      S_M4:    begin op_a = 33'(dx_r);          op_b = 33'(rely_r); end
      S_M5:    begin op_a = 33'(k_r);           op_b = 33'(k_r); end
      S_M6:    begin op_a = 33'(ac[30:0]);      op_b = 33'(ac[30:0]); end
      S_M7:    begin op_a = 33'(kk_r);          op_b = 33'(s_r); end
      S_O1:    begin op_a = 33'(d);             op_b = 33'(d); end
      S_O2:    begin op_a = 33'(mul_r[30:0]);   op_b = 33'(kk_r); end
      S_T1:    begin op_a = 33'(cand);          op_b = 33'(cand); end
      S_T2:    begin op_a = 33'(mul_r[25:0]);   op_b = 33'(s_r); end
      default: begin op_a = '0;                 op_b = '0; end
    endcase
    prod = op_a * op_b;

    px1  = 18'(q_r.sx) + 18'(ox_r);
    px2  = 18'(q_r.gx) + 18'(ox_r);
    py1  = 18'(q_r.sy) + 18'(oy_r);
    py2  = 18'(q_r.gy) + 18'(oy_r);
    minx = (px1 < px2) ? px1 : px2;
    maxx = (px1 > px2) ? px1 : px2;
    miny = (py1 < py2) ? py1 : py2;
    maxy = (py1 > py2) ? py1 : py2;
    cxp  = 18'(o_r.cx) + $signed(18'(o_r.rad));
    cxm  = 18'(o_r.cx) - $signed(18'(o_r.rad));
    cyp  = 18'(o_r.cy) + $signed(18'(o_r.rad));
    cym  = 18'(o_r.cy) - $signed(18'(o_r.rad));
    box_hit = (cxp > minx) && (cxm < maxx) && (cyp > miny) && (cym < maxy);
  end

  assign done = (st_r == S_DONE);
  assign hit  = hit_r;

  always_ff @(posedge clk) begin
    mul_r <= prod[63:0];
    case (st_r)
      S_IDLE: begin
        q_r <= q;
        o_r <= o;
      end
      S_PREP: begin
        dx_r   <= 16'(q_r.gx) - 16'(q_r.sx);
        dy_r   <= 16'(q_r.gy) - 16'(q_r.sy);
        relx_r <= 16'(o_r.cx) - 16'(q_r.sx);
        rely_r <= 16'(o_r.cy) - 16'(q_r.sy);
        k_r    <= 13'(o_r.rad) + 13'(q_r.margin);
      end
      S_M2: s_r  <= mul_r[31:0];
      S_M3: s_r  <= s_r + mul_r[31:0];
      S_M4: cr_r <= mul_r[33:0];
      S_M5: cr_r <= cr_r - mul_r[33:0];
      S_M6: begin
        kk_r  <= mul_r[25:0];
        big_r <= |ac[33:31];
      end
      S_M7: acq_r <= mul_r[62:0];
      S_NUM: begin
        num_r  <= mul_r[56:0];
        lo_r   <= '0;
        bidx_r <= 4'd12;
      end
      S_TCHK: begin
        lo_r   <= lo_nxt;
        bidx_r <= bidx_r - 4'd1;
        if (bidx_r == 4'd0) begin
          if (ph_r) oy_r <= off_nxt;
          else      ox_r <= off_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ph_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (start) st_r <= S_PREP;
        S_PREP: st_r <= S_M1;
        S_M1:   st_r <= S_M2;
        S_M2:   st_r <= S_M3;
        S_M3:   st_r <= S_M4;
        S_M4:   st_r <= S_M5;
        S_M5:   st_r <= S_M6;
        S_M6:   st_r <= S_M7;
        S_M7:   st_r <= S_CMP;
        S_CMP: begin
          if (big_r || !(acq_r < mul_r[62:0])) begin
            hit_r <= 1'b0;
            st_r  <= S_DONE;
          end else begin
            ph_r <= 1'b0;
            st_r <= S_O1;
          end
        end
        S_O1:  st_r <= S_O2;
        S_O2:  st_r <= S_NUM;
        S_NUM: st_r <= S_T1;
        S_T1:  st_r <= S_T2;
        S_T2:  st_r <= S_TCHK;
        S_TCHK: begin
          if (bidx_r != 4'd0) begin
            st_r <= S_T1;
          end else if (!ph_r) begin
            ph_r <= 1'b1;
            st_r <= S_O1;
          end else begin
            st_r <= S_BOX;
          end
        end
        S_BOX: begin
          hit_r <= box_hit;
          st_r  <= S_DONE;
        end
        S_DONE:  st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/socc_back.sv =====
`default_nettype none
module socc_back #(
  parameter int MAX_OBSTACLES = socc_pkg::MaxObstacles
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cmd_valid,
  output logic                                cmd_ready,
  input  wire socc_pkg::cmd_t                 cmd,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [14:0]                    cfg_wdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [socc_pkg::OutDataW-1:0]       out_tdata
);

  localparam int IDXW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CNTW = $clog2(MAX_OBSTACLES + 1);
  localparam int JW   = $clog2(MAX_OBSTACLES + 2);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_FETCH  = 3'd1;
  localparam logic [2:0] B_START  = 3'd2;
  localparam logic [2:0] B_WAIT   = 3'd3;
  localparam logic [2:0] B_RESULT = 3'd4;

  socc_pkg::obs_t      mem [MAX_OBSTACLES];
  socc_pkg::obs_t      rd_r;
  logic [2:0]          st_r;
  logic [CNTW-1:0]     cnt_r;
  logic [JW-1:0]       j_r;
  socc_pkg::cmd_t      cmd_r;
  logic                res_blocked_r, res_status_r;
  logic                out_valid_r, out_blocked_r, out_status_r;
  logic [13:0]         fx_max_r;
  logic signed [14:0]  fx_min_r;
  logic [11:0]         pen_r;

  logic                take, room, hit_start, hit_done, hit_hit, last_j;
  socc_pkg::obs_t      obs;

  assign cmd_ready = (st_r == B_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign room      = (cnt_r < CNTW'(MAX_OBSTACLES));
  assign hit_start = (st_r == B_START);
  assign last_j    = (j_r == JW'(cnt_r) + JW'(1));

  always_comb begin
    if (j_r < JW'(cnt_r)) begin
      obs = rd_r;
    end else if (j_r == JW'(cnt_r)) begin
      obs.cx  = $signed({1'b0, fx_max_r});
      obs.cy  = '0;
      obs.rad = pen_r;
    end else begin
      obs.cx  = fx_min_r;
      obs.cy  = '0;
      obs.rad = pen_r;
    end
  end

  socc_hit u_hit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hit_start),
    .q     (cmd_r.q),
    .o     (obs),
    .done  (hit_done),
    .hit   (hit_hit)
  );

  always_ff @(posedge clk) begin
    rd_r <= mem[j_r[IDXW-1:0]];
    if (take && cmd.action == socc_pkg::ACT_APPEND && room) begin
      mem[cnt_r[IDXW-1:0]] <= cmd.o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_max_r <= socc_pkg::XMaxReset;
      fx_min_r <= socc_pkg::XMinReset;
      pen_r    <= socc_pkg::PenReset;
    end else if (cfg_we) begin
      case (cfg_index)
        socc_pkg::CFG_X_MAX: fx_max_r <= cfg_wdata[13:0];
        socc_pkg::CFG_X_MIN: fx_min_r <= $signed(cfg_wdata);
        socc_pkg::CFG_PEN:   pen_r    <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= B_IDLE;
      cnt_r         <= '0;
      j_r           <= '0;
      res_blocked_r <= 1'b0;
      res_status_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      out_blocked_r <= 1'b0;
      out_status_r  <= 1'b0;
    end else begin
      if (st_r == B_RESULT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        B_IDLE: begin
          if (take) begin
            cmd_r         <= cmd;
            res_blocked_r <= 1'b0;
            res_status_r  <= 1'b0;
            j_r           <= '0;
            st_r          <= B_RESULT;
            case (cmd.action)
              socc_pkg::ACT_CLEAR: cnt_r <= '0;
              socc_pkg::ACT_APPEND: begin
                if (room) cnt_r <= cnt_r + CNTW'(1);
                else      res_status_r <= 1'b1;
              end
              socc_pkg::ACT_QUERY: if (!cmd.same) st_r <= B_FETCH;
              default: ;
            endcase
          end
        end
        B_FETCH: st_r <= B_START;
        B_START: st_r <= B_WAIT;
        B_WAIT: begin
          if (hit_done) begin
            if (hit_hit) begin
              res_blocked_r <= 1'b1;
              st_r          <= B_RESULT;
            end else if (last_j) begin
              st_r <= B_RESULT;
            end else begin
              j_r  <= j_r + JW'(1);
              st_r <= B_FETCH;
            end
          end
        end
        B_RESULT: begin
          if (!out_valid_r || out_tready) begin
            out_blocked_r <= res_blocked_r;
            out_status_r  <= res_status_r;
            st_r          <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_blocked_r};

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MAX_OBSTACLES))
    else $error("obstacle count over capacity");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    hit_done |-> st_r == B_WAIT)
    else $error("hit unit finished outside wait");

  a_status_append: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_RESULT && res_status_r) |-> cmd_r.action == socc_pkg::ACT_APPEND)
    else $error("full-table status on non-append");

  a_blocked_query: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_RESULT && res_blocked_r) |-> cmd_r.action == socc_pkg::ACT_QUERY)
    else $error("blocked on non-query");

endmodule
`default_nettype wire
